>>> rtl/binary_map_rectangle_finder_defines.svh
// Assertion macros of the rectangle finder RTL.
`ifndef BINARY_MAP_RECTANGLE_FINDER_DEFINES_SVH
`define BINARY_MAP_RECTANGLE_FINDER_DEFINES_SVH

`ifndef SYNTHESIS
// Property checked on every rising clock edge outside reset.
`define BMRF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Condition in one cycle implies a consequence in the next.
`define BMRF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BMRF_ASSERT(lbl, prop, msg)
`define BMRF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/bmrf_pkg.sv
// Types, constants and helper functions of the rectangle finder.
`default_nettype none
package bmrf_pkg;

	localparam int MAX_DIM = 64;
	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int IDX_W = $clog2(MAX_DIM);
	localparam int AREA_W = $clog2(MAX_DIM * MAX_DIM + 1);
	localparam int CFG_W = DIM_W;
	localparam int REG_IDX_W = 1;
	localparam int NUM_BEST = 3;
	localparam int SEL_W = 2;

	// Register indexes of the configuration port
	localparam logic [REG_IDX_W-1:0] REG_FRAME_ROWS = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_FRAME_COLS = 1'd1;

	// Record selectors
	localparam logic [SEL_W-1:0] SEL_BASE = 2'd0;
	localparam logic [SEL_W-1:0] SEL_HEIGHT = 2'd1;
	localparam logic [SEL_W-1:0] SEL_AREA = 2'd2;

	typedef struct packed {
		logic [IDX_W-1:0] crow;
		logic [IDX_W-1:0] ccol;
		logic [DIM_W-1:0] base;
		logic [DIM_W-1:0] height;
		logic [AREA_W-1:0] area;
	} rec_t;

	// Zero acts as one, values beyond the maximum act as the maximum
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) r = DIM_W'(1);
		else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
		else r = v;
		return r;
	endfunction

	function automatic logic [AREA_W-1:0] metric(input rec_t x, input logic [SEL_W-1:0] k);
		logic [AREA_W-1:0] m;
		unique case (k)
			SEL_BASE:   m = AREA_W'(x.base);
			SEL_HEIGHT: m = AREA_W'(x.height);
			default:    m = x.area;
		endcase
		return m;
	endfunction

	// Raster order of two corners
	function automatic logic corner_before(input rec_t a, input rec_t b);
		logic r;
		if (a.crow != b.crow) r = a.crow < b.crow;
		else r = a.ccol < b.ccol;
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/bmrf_pix_if.sv
// Pixel stream channel.
`default_nettype none
interface bmrf_pix_if;
	logic valid;
	logic ready;
	logic pixel;

	modport source (output valid, output pixel, input ready);
	modport sink (input valid, input pixel, output ready);
endinterface
`default_nettype wire

>>> rtl/bmrf_rec_if.sv
// Result record channel.
`default_nettype none
interface bmrf_rec_if
	import bmrf_pkg::*;
;
	logic valid;
	logic ready;
	logic [SEL_W-1:0] which_best;
	logic [IDX_W-1:0] corner_row;
	logic [IDX_W-1:0] corner_col;
	logic [DIM_W-1:0] base;
	logic [DIM_W-1:0] height;
	logic [AREA_W-1:0] area;
	logic last;

	modport source (output valid, output which_best, output corner_row, output corner_col,
		output base, output height, output area, output last, input ready);
	modport sink (input valid, input which_best, input corner_row, input corner_col,
		input base, input height, input area, input last, output ready);
endinterface
`default_nettype wire

>>> rtl/binary_map_rectangle_finder.sv
// Top level of the rectangle finder: column tables, run tracking, best records.
//
//   channel   dir  payload                                              handshake
//   pixels    in   pixel                                                valid/ready
//   records   out  which_best corner_row corner_col base height area last  valid/ready
//   config    in   wr_index wr_data                                     wr_en
//
// One pixel per cycle. The column tables are read at accept and written back in the cycle
// after; a write-back register forwards to a read of the same column in the next cycle.
// After the frame's last pixel passes the pipeline, its three records are latched and sent in turn.
// A frame's last pixel waits while the previous frame's records are still in flight or
// not all taken; other pixels are never stalled. Reset clears counters, records and the
// valid bits of the row-above table at once, with no clearing pass.
`default_nettype none
`include "binary_map_rectangle_finder_defines.svh"
module binary_map_rectangle_finder
	import bmrf_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [REG_IDX_W-1:0] wr_index,
	input  wire logic [CFG_W-1:0]     wr_data,
	bmrf_pix_if.sink                  pixels,
	bmrf_rec_if.source                records
);

	// Configuration
	logic [DIM_W-1:0] frame_rows_q, frame_cols_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_rows_q <= DIM_W'(MAX_DIM);
			frame_cols_q <= DIM_W'(MAX_DIM);
		end else if (wr_en) begin
			unique case (wr_index)
				REG_FRAME_ROWS: frame_rows_q <= wr_data;
				REG_FRAME_COLS: frame_cols_q <= wr_data;
				default: ;
			endcase
		end
	end

	// Raster position of the incoming pixel
	logic [IDX_W-1:0] row_q, col_q;
	logic [DIM_W-1:0] rows_eff, cols_eff;
	logic [IDX_W-1:0] rmax, cmax, r_now, c_now;
	logic lastcol_now, eof_now, accept;

	assign rows_eff = clamp_dim(frame_rows_q);
	assign cols_eff = clamp_dim(frame_cols_q);
	assign rmax = IDX_W'(rows_eff - DIM_W'(1));
	assign cmax = IDX_W'(cols_eff - DIM_W'(1));
	assign r_now = ({1'b0, row_q} >= rows_eff) ? rmax : row_q;
	assign c_now = ({1'b0, col_q} >= cols_eff) ? cmax : col_q;
	assign lastcol_now = (c_now == cmax);
	assign eof_now = lastcol_now && (r_now == rmax);

	// Pipeline and output occupancy
	logic v_s1, eof_s1, eof_s2, eof_s3, out_busy_q, eof_in_flight;
	assign eof_in_flight = eof_s1 || eof_s2 || eof_s3;
	assign pixels.ready = !(eof_now && (eof_in_flight || out_busy_q));
	assign accept = pixels.valid && pixels.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (lastcol_now) begin
				col_q <= '0;
				row_q <= eof_now ? '0 : r_now + IDX_W'(1);
			end else begin
				col_q <= c_now + IDX_W'(1);
				row_q <= r_now;
			end
		end
	end

	// Column tables: pixel above and top row of the column's 1-segment
	logic             above_mem [MAX_DIM];
	logic [IDX_W-1:0] top_mem [MAX_DIM];
	logic [MAX_DIM-1:0] above_vld_q;

	logic             p_s1, lastcol_s1, above_rd_s1, above_ok_s1;
	logic [IDX_W-1:0] r_s1, c_s1, top_rd_s1;
	logic             a, top_we, above_eff;
	logic [IDX_W-1:0] top_eff;

	// Write-back register for forwarding to the next read
	logic             fwd_v_q, fwd_above_q, fwd_top_we_q;
	logic [IDX_W-1:0] fwd_addr_q, fwd_top_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			above_rd_s1 <= above_mem[c_now];
			top_rd_s1 <= top_mem[c_now];
			above_ok_s1 <= above_vld_q[c_now];
			p_s1 <= pixels.pixel;
			r_s1 <= r_now;
			c_s1 <= c_now;
			lastcol_s1 <= lastcol_now;
		end
		if (v_s1) begin
			above_mem[c_s1] <= p_s1;
			if (top_we) top_mem[c_s1] <= r_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			eof_s1 <= 1'b0;
			above_vld_q <= '0;
			fwd_v_q <= 1'b0;
		end else begin
			v_s1 <= accept;
			eof_s1 <= accept && eof_now;
			fwd_v_q <= v_s1;
			if (v_s1 && eof_s1) above_vld_q <= '0;
			else if (v_s1) above_vld_q[c_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			fwd_addr_q <= c_s1;
			fwd_above_q <= p_s1;
			fwd_top_we_q <= top_we;
			fwd_top_q <= r_s1;
		end
	end

	// Stage 1: resolve the column entries and track the current run
	logic             fwd_hit;
	logic             left_q;
	logic [IDX_W-1:0] run_start_q, run_top_q;
	logic             start, score_mid, score_end, score;
	logic [IDX_W-1:0] s_eff, top_run, crow;
	rec_t             cand;

	assign fwd_hit = fwd_v_q && (fwd_addr_q == c_s1);
	assign above_eff = fwd_hit ? fwd_above_q : (above_ok_s1 && above_rd_s1);
	assign top_eff = (fwd_hit && fwd_top_we_q) ? fwd_top_q : top_rd_s1;
	assign a = (r_s1 != '0) && above_eff;
	assign top_we = p_s1 && !a;
	assign start = p_s1 && !left_q;
	assign s_eff = start ? c_s1 : run_start_q;
	assign top_run = start ? (a ? top_eff : r_s1) : run_top_q;
	assign score_mid = !p_s1 && left_q;
	assign score_end = p_s1 && lastcol_s1;
	assign score = v_s1 && (score_mid || score_end);
	assign crow = (top_run > r_s1) ? r_s1 : top_run;

	always_comb begin
		cand.crow = crow;
		cand.ccol = s_eff;
		cand.base = {1'b0, c_s1} - {1'b0, s_eff} + DIM_W'(score_end);
		cand.height = {1'b0, r_s1} - {1'b0, crow} + DIM_W'(1);
		cand.area = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= 1'b0;
			run_start_q <= '0;
			run_top_q <= '0;
		end else if (v_s1) begin
			left_q <= lastcol_s1 ? 1'b0 : p_s1;
			if (start) begin
				run_start_q <= c_s1;
				run_top_q <= top_run;
			end
		end
	end

	// Stage 2: area of the scored run
	logic sc_s2, sc_s3;
	rec_t cand_s2, cand_s3;
	logic [2*DIM_W-1:0] prod;

	assign prod = cand_s2.base * cand_s2.height;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_s2 <= 1'b0;
			eof_s2 <= 1'b0;
			sc_s3 <= 1'b0;
			eof_s3 <= 1'b0;
		end else begin
			sc_s2 <= score;
			eof_s2 <= eof_s1;
			sc_s3 <= sc_s2;
			eof_s3 <= eof_s2;
		end
	end

	always_ff @(posedge clk) begin
		cand_s2 <= cand;
		cand_s3 <= cand_s2;
		cand_s3.area <= prod[AREA_W-1:0];
	end

	// Stage 3: compare against the best records
	rec_t best_q [NUM_BEST];
	rec_t best_nxt [NUM_BEST];

	always_comb begin
		for (int k = 0; k < NUM_BEST; k++) begin
			logic [AREA_W-1:0] mn, mb;
			logic take;
			mn = metric(cand_s3, SEL_W'(k));
			mb = metric(best_q[k], SEL_W'(k));
			take = (best_q[k].base == '0)
				|| (best_q[k].crow == cand_s3.crow && best_q[k].ccol == cand_s3.ccol)
				|| (mn > mb)
				|| (mn == mb && corner_before(cand_s3, best_q[k]));
			best_nxt[k] = (sc_s3 && take) ? cand_s3 : best_q[k];
		end
	end

	rec_t out_rec_q [NUM_BEST];
	logic [SEL_W-1:0] out_idx_q;
	logic out_xfer;

	assign out_xfer = records.valid && records.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_BEST; k++) best_q[k] <= '0;
		end else begin
			for (int k = 0; k < NUM_BEST; k++) best_q[k] <= eof_s3 ? '0 : best_nxt[k];
		end
	end

	// Frame's records latched for output
	always_ff @(posedge clk) begin
		if (eof_s3) begin
			for (int k = 0; k < NUM_BEST; k++) out_rec_q[k] <= best_nxt[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_busy_q <= 1'b0;
			out_idx_q <= SEL_BASE;
		end else if (eof_s3) begin
			out_busy_q <= 1'b1;
			out_idx_q <= SEL_BASE;
		end else if (out_xfer) begin
			if (out_idx_q == SEL_AREA) out_busy_q <= 1'b0;
			else out_idx_q <= out_idx_q + SEL_W'(1);
		end
	end

	// Output channel
	rec_t out_cur;
	assign out_cur = out_rec_q[out_idx_q];
	assign records.valid = out_busy_q;
	assign records.which_best = out_idx_q;
	assign records.corner_row = out_cur.crow;
	assign records.corner_col = out_cur.ccol;
	assign records.base = out_cur.base;
	assign records.height = out_cur.height;
	assign records.area = out_cur.area;
	assign records.last = (out_idx_q == SEL_AREA);

	// Checks
	`BMRF_ASSERT(a_one_frame_end, $countones({eof_s1, eof_s2, eof_s3}) <= 1, "two frame ends in flight")
	`BMRF_ASSERT(a_no_overlap, !(out_busy_q && eof_in_flight), "frame end in flight while records pending")
	`BMRF_ASSERT_NEXT(a_load, eof_s3, out_busy_q && out_idx_q == SEL_BASE, "records not loaded at frame end")
	`BMRF_ASSERT_NEXT(a_drain, out_xfer && out_idx_q == SEL_AREA, !out_busy_q, "records not drained after last")

endmodule
`default_nettype wire

>>> tb/binary_map_rectangle_finder_tb.sv
// Self-checking testbench of the rectangle finder: raster frames in, best-rectangle records out.
module binary_map_rectangle_finder_tb;
	import bmrf_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 12;
	localparam int LIMIT_CYCLES = 300000;
	localparam int RANDOM_ITEMS = 370;

	typedef enum {FRAME_RECTS, FRAME_NOISE} frame_kind_e;

	typedef struct packed {
		logic [SEL_W-1:0]  which_best;
		logic [IDX_W-1:0]  corner_row;
		logic [IDX_W-1:0]  corner_col;
		logic [DIM_W-1:0]  base;
		logic [DIM_W-1:0]  height;
		logic [AREA_W-1:0] area;
		logic              last;
	} record_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [REG_IDX_W-1:0] wr_index;
	logic [CFG_W-1:0] wr_data;

	bmrf_pix_if pix_ch ();
	bmrf_rec_if rec_ch ();

	binary_map_rectangle_finder uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.pixels   (pix_ch),
		.records  (rec_ch)
	);

	// Stimulus bookkeeping
	bit pixel_queue[$];
	int unsigned pixels_queued;
	int unsigned pixels_accepted;
	int unsigned frames_queued;
	int unsigned random_items;
	int unsigned errors;
	int unsigned cycles;
	bit pix_taken;
	int unsigned pix_gap;
	int unsigned pix_steady;
	int unsigned hold_requests;
	int unsigned holds_served;
	int unsigned hold_left;
	int unsigned stall_left;
	int unsigned calm_left;

	// Predictor state
	logic [CFG_W-1:0] rows_reg;
	logic [CFG_W-1:0] cols_reg;
	bit px_above[MAX_DIM];
	int unsigned seg_top[MAX_DIM];
	int unsigned cur_row;
	int unsigned cur_col;
	int unsigned run_first;
	bit px_left;
	rec_t best_by[NUM_BEST];
	record_t records_due[$];

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Zero acts as one, anything beyond the table depth as the full depth
	function automatic int unsigned effective_size(input logic [CFG_W-1:0] raw);
		if (raw == '0) return 1;
		if (raw > CFG_W'(MAX_DIM)) return MAX_DIM;
		return raw;
	endfunction

	function automatic int unsigned size_of(input rec_t x, input logic [SEL_W-1:0] sel);
		case (sel)
			SEL_BASE:   return x.base;
			SEL_HEIGHT: return x.height;
			default:    return x.area;
		endcase
	endfunction

	function automatic bit earlier_corner(input rec_t a, input rec_t b);
		if (a.crow != b.crow) return a.crow < b.crow;
		return a.ccol < b.ccol;
	endfunction

	function automatic void start_new_frame();
		foreach (px_above[i]) px_above[i] = 1'b0;
		foreach (best_by[k]) best_by[k] = '0;
		cur_row = 0;
		cur_col = 0;
		run_first = 0;
		px_left = 1'b0;
	endfunction

	function automatic void reset_predictor();
		rows_reg = CFG_W'(MAX_DIM);
		cols_reg = CFG_W'(MAX_DIM);
		foreach (seg_top[i]) seg_top[i] = 0;
		start_new_frame();
	endfunction

	// A finished run of ones in row r, columns s..e, against the three leaders
	function automatic void score_region(input int unsigned s, input int unsigned e,
			input int unsigned r);
		rec_t cand;
		int unsigned top;
		logic [SEL_W-1:0] sel;
		int unsigned mine;
		int unsigned theirs;
		bit take;
		top = seg_top[s];
		if (top > r) top = r;
		cand.crow = IDX_W'(top);
		cand.ccol = IDX_W'(s);
		cand.base = DIM_W'(e - s + 1);
		cand.height = DIM_W'(r - top + 1);
		cand.area = AREA_W'((e - s + 1) * (r - top + 1));
		// leader index equals the selector code
		for (int k = 0; k < NUM_BEST; k++) begin
			sel = SEL_W'(k);
			mine = size_of(cand, sel);
			theirs = size_of(best_by[k], sel);
			if (best_by[k].base == '0) take = 1'b1;
			else if (best_by[k].crow == cand.crow && best_by[k].ccol == cand.ccol) take = 1'b1;
			else if (mine > theirs) take = 1'b1;
			else take = (mine == theirs) && earlier_corner(cand, best_by[k]);
			if (take) best_by[k] = cand;
		end
	endfunction

	// One accepted pixel; the frame's last pixel releases three records
	function automatic void predict_pixel(input bit p);
		int unsigned nr;
		int unsigned nc;
		int unsigned r;
		int unsigned c;
		bit up;
		record_t rec;
		nr = effective_size(rows_reg);
		nc = effective_size(cols_reg);
		if (cur_col >= nc) cur_col = nc - 1;
		if (cur_row >= nr) cur_row = nr - 1;
		r = cur_row;
		c = cur_col;
		up = (r > 0) ? px_above[c] : 1'b0;
		if (p) begin
			if (!px_left) run_first = c;
			if (!up) seg_top[c] = r;
		end else if (px_left) begin
			score_region(run_first, c - 1, r);
		end
		px_above[c] = p;
		px_left = p;
		if (c == nc - 1) begin
			if (p) score_region(run_first, c, r);
			px_left = 1'b0;
			if (r == nr - 1) begin
				for (int k = 0; k < NUM_BEST; k++) begin
					rec.which_best = SEL_W'(k);
					rec.corner_row = best_by[k].crow;
					rec.corner_col = best_by[k].ccol;
					rec.base = best_by[k].base;
					rec.height = best_by[k].height;
					rec.area = best_by[k].area;
					rec.last = (rec.which_best == SEL_AREA);
					records_due.push_back(rec);
				end
				start_new_frame();
				return;
			end
			cur_col = 0;
			cur_row = r + 1;
		end else begin
			cur_col = c + 1;
		end
	endfunction

	function automatic void check_field(input string name, input logic [AREA_W-1:0] want,
			input logic [AREA_W-1:0] got);
		if (got !== want) begin
			$display("%0t: record %s expected %0d got %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	function automatic void check_record();
		record_t want;
		if (records_due.size() == 0) begin
			$display("%0t: record expected none got which_best %0d", $time, rec_ch.which_best);
			errors++;
			return;
		end
		want = records_due.pop_front();
		check_field("which_best", want.which_best, rec_ch.which_best);
		check_field("corner_row", want.corner_row, rec_ch.corner_row);
		check_field("corner_col", want.corner_col, rec_ch.corner_col);
		check_field("base", want.base, rec_ch.base);
		check_field("height", want.height, rec_ch.height);
		check_field("area", want.area, rec_ch.area);
		check_field("last", want.last, rec_ch.last);
	endfunction

	// Mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) return 0;
		if (roll < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Rising edge: register writes, pixel transfers, record checks, run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("binary_map_rectangle_finder_tb failed");
			$finish;
		end else if (arst_n) begin
			if (wr_en) begin
				if (wr_index == REG_FRAME_ROWS) rows_reg = wr_data;
				else if (wr_index == REG_FRAME_COLS) cols_reg = wr_data;
			end
			pix_taken = pix_ch.valid && pix_ch.ready;
			if (pix_taken) begin
				predict_pixel(pix_ch.pixel);
				pixels_accepted++;
			end
			if (rec_ch.valid && rec_ch.ready) check_record();
		end
	end

	// Pixel driver: offers the next queued pixel at the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			pix_ch.valid <= 1'b0;
		end else if (!pix_ch.valid || pix_taken) begin
			if (pix_gap != 0) begin
				pix_ch.valid <= 1'b0;
				pix_gap <= pix_gap - 1;
			end else if (pixel_queue.size() != 0) begin
				pix_ch.valid <= 1'b1;
				pix_ch.pixel <= pixel_queue.pop_front();
				pix_gap <= (pix_steady != 0) ? 0 : pick_gap();
				if (pix_steady != 0) pix_steady <= pix_steady - 1;
				else if ($urandom_range(0, 15) == 0) pix_steady <= $urandom_range(20, 60);
			end else begin
				pix_ch.valid <= 1'b0;
			end
		end
	end

	// Record receiver: random stalls, calm stretches and the requested long hold
	always @(negedge clk) begin
		if (!arst_n) begin
			rec_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			rec_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (holds_served != hold_requests) begin
			rec_ch.ready <= 1'b0;
			holds_served <= holds_served + 1;
			hold_left <= HOLD_CYCLES;
		end else if (stall_left != 0) begin
			rec_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			rec_ch.ready <= 1'b1;
			if (calm_left != 0) calm_left <= calm_left - 1;
			else if ($urandom_range(0, 19) == 0) calm_left <= $urandom_range(20, 60);
			else if ($urandom_range(0, 2) == 0) stall_left <= pick_gap();
		end
	end

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic set_frame(input logic [CFG_W-1:0] rows_raw, input logic [CFG_W-1:0] cols_raw);
		write_reg(REG_FRAME_ROWS, rows_raw);
		write_reg(REG_FRAME_COLS, cols_raw);
	endtask

	// Everything sent has been taken and answered, and the pipeline has drained
	task automatic wait_idle();
		do @(negedge clk);
		while (pixels_accepted != pixels_queued || records_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic queue_pattern(input string bits);
		@(posedge clk);
		for (int i = 0; i < bits.len(); i++) pixel_queue.push_back(bits[i] == "1");
		pixels_queued += bits.len();
	endtask

	// One whole frame: separate rectangles, or random noise
	task automatic queue_frame(input logic [CFG_W-1:0] rows_raw, input logic [CFG_W-1:0] cols_raw,
			input frame_kind_e kind);
		bit cells[MAX_DIM][MAX_DIM];
		int unsigned nr;
		int unsigned nc;
		int unsigned top;
		int unsigned lft;
		int unsigned hgt;
		int unsigned wid;
		int unsigned density;
		bit open;
		nr = effective_size(rows_raw);
		nc = effective_size(cols_raw);
		if (kind == FRAME_NOISE) begin
			density = $urandom_range(1, 3);
			for (int i = 0; i < nr; i++)
				for (int j = 0; j < nc; j++) cells[i][j] = ($urandom_range(0, 3) < density);
		end else begin
			// keep a one-cell margin so that rectangles never touch
			repeat ($urandom_range(0, 5)) begin
				top = $urandom_range(0, nr - 1);
				lft = $urandom_range(0, nc - 1);
				hgt = $urandom_range(1, nr - top);
				wid = $urandom_range(1, nc - lft);
				open = 1'b1;
				for (int i = (top == 0) ? 0 : top - 1; i <= top + hgt && i < nr; i++)
					for (int j = (lft == 0) ? 0 : lft - 1; j <= lft + wid && j < nc; j++)
						if (cells[i][j]) open = 1'b0;
				if (open)
					for (int i = top; i < top + hgt; i++)
						for (int j = lft; j < lft + wid; j++) cells[i][j] = 1'b1;
			end
		end
		@(posedge clk);
		for (int i = 0; i < nr; i++)
			for (int j = 0; j < nc; j++) pixel_queue.push_back(cells[i][j]);
		pixels_queued += nr * nc;
		frames_queued++;
	endtask

	initial begin : stimulus
		logic [CFG_W-1:0] rows_raw;
		logic [CFG_W-1:0] cols_raw;
		int unsigned roll;
		int unsigned before_phase;
		pix_ch.valid = 1'b0;
		pix_ch.pixel = 1'b0;
		rec_ch.ready = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_FRAME_ROWS;
		wr_data = '0;
		arst_n = 1'b0;
		reset_predictor();
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// Empty map, row register at zero
		set_frame('0, 7'd3);
		queue_pattern("000");
		wait_idle();
		// Single-cell frame holding one black cell
		set_frame(7'd1, 7'd1);
		queue_pattern("1");
		wait_idle();
		// Shrink rows and columns mid-frame: counters saturate, stored top lies below
		set_frame(7'd4, 7'd4);
		queue_pattern("000000000110011");
		wait_idle();
		set_frame(7'd2, 7'd3);
		queue_pattern("0");
		wait_idle();

		// Widest and tallest frames, column register beyond range
		before_phase = pixels_queued;
		set_frame(7'd1, 7'd127);
		queue_frame(7'd1, 7'd127, FRAME_NOISE);
		wait_idle();
		set_frame(7'd64, 7'd1);
		queue_frame(7'd64, 7'd1, FRAME_RECTS);
		wait_idle();

		// Receiver holds off while frames keep coming, so the last pixel stalls
		set_frame(7'd2, 7'd3);
		@(posedge clk);
		hold_requests++;
		repeat (4) queue_frame(7'd2, 7'd3, FRAME_RECTS);
		wait_idle();
		random_items = pixels_queued - before_phase;

		// Random phases: one setting, a few frames each
		while (random_items < RANDOM_ITEMS || frames_queued < 20) begin
			before_phase = pixels_queued;
			roll = $urandom_range(0, 9);
			if (roll == 0) begin
				rows_raw = ($urandom_range(0, 1) != 0) ? CFG_W'(MAX_DIM) : $urandom_range(65, 127);
				cols_raw = $urandom_range(0, 2);
			end else if (roll == 1) begin
				rows_raw = $urandom_range(0, 2);
				cols_raw = ($urandom_range(0, 1) != 0) ? CFG_W'(MAX_DIM) : $urandom_range(65, 127);
			end else begin
				rows_raw = $urandom_range(1, 6);
				cols_raw = $urandom_range(1, 6);
			end
			set_frame(rows_raw, cols_raw);
			repeat ($urandom_range(1, 4))
				queue_frame(rows_raw, cols_raw,
					($urandom_range(0, 4) == 0) ? FRAME_NOISE : FRAME_RECTS);
			wait_idle();
			random_items += pixels_queued - before_phase;
		end

		if (errors == 0) begin
			$display("binary_map_rectangle_finder_tb passed");
		end else begin
			$display("binary_map_rectangle_finder_tb failed");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/bmrf_pkg.sv
rtl/bmrf_pix_if.sv
rtl/bmrf_rec_if.sv
rtl/binary_map_rectangle_finder.sv
tb/binary_map_rectangle_finder_tb.sv
